@@ rtl/timestamped_first_order_lowpass_top_assert.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the timestamped low-pass filter
// ---------------------------------------------------------------------------
`ifndef TIMESTAMPED_FIRST_ORDER_LOWPASS_TOP_ASSERT_SVH
`define TIMESTAMPED_FIRST_ORDER_LOWPASS_TOP_ASSERT_SVH

// same-cycle implication
`define TFOL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tfol_pkg.sv @@
// ---------------------------------------------------------------------------
// tfol_pkg
// shared types and constants of the timestamped low-pass filter
// ---------------------------------------------------------------------------
package tfol_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_TC_IDX    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_LIMIT_IDX = 2'd1;

  localparam logic [CFG_W-1:0] TC_RESET    = 32'd8400000;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 32'd50400000;

  // request to the serial multiply/divide unit
  typedef struct packed {
    logic              start;
    logic [CFG_W-1:0]  tc;
    logic [CFG_W-1:0]  dt;
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] x;
  } md_req_t;

  // response from the serial multiply/divide unit
  typedef struct packed {
    logic              done;
    logic              neg;
    logic [DATA_W-1:0] quot;
  } md_rsp_t;

endpackage

@@ rtl/tfol_muldiv.sv @@
// ---------------------------------------------------------------------------
// tfol_muldiv
// bit-serial weighted sum tc*prev + dt*x followed by a restoring divide by
// tc + dt, one bit per cycle, giving sign and magnitude of the quotient
// ---------------------------------------------------------------------------
module tfol_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  tfol_pkg::md_req_t req,
  output tfol_pkg::md_rsp_t rsp
);

  localparam int unsigned DW   = tfol_pkg::DATA_W;
  localparam int unsigned CW   = tfol_pkg::CFG_W;
  localparam int unsigned HW   = CW + 2;            // upper product half
  localparam int unsigned CNTW = $clog2(CW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_DIV
  } md_state_t;

  md_state_t          state_r;
  logic [CNTW-1:0]    cnt_r;
  logic [CW-1:0]      mtc_r;
  logic [CW-1:0]      mdt_r;
  logic [DW-1:0]      prev_r;
  logic [DW-1:0]      x_r;
  logic [CW:0]        den_r;
  logic [HW-1:0]      hi_r;
  logic [DW-1:0]      lo_r;
  logic [CW:0]        rem_r;
  logic               neg_r;
  logic               done_r;

  logic [HW:0]        addend;
  logic [HW:0]        hsum;
  logic [HW+DW-1:0]   prod;
  logic [HW+DW-1:0]   mag;
  logic [CW+1:0]      trial;
  logic [CW+1:0]      diff;
  logic               ge;

  always_comb begin
    addend = '0;
    if (mtc_r[0]) begin
      addend = addend + (HW+1)'(signed'(prev_r));
    end
    if (mdt_r[0]) begin
      addend = addend + (HW+1)'(signed'(x_r));
    end
    hsum  = {hi_r[HW-1], hi_r} + addend;
    prod  = {hi_r, lo_r};
    mag   = prod[HW+DW-1] ? (HW+DW)'(0) - prod : prod;
    trial = {rem_r, lo_r[DW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            mtc_r   <= req.tc;
            mdt_r   <= req.dt;
            prev_r  <= req.prev;
            x_r     <= req.x;
            den_r   <= {1'b0, req.tc} + {1'b0, req.dt};
            hi_r    <= '0;
            lo_r    <= '0;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          hi_r  <= hsum[HW:1];
          lo_r  <= {hsum[0], lo_r[DW-1:1]};
          mtc_r <= mtc_r >> 1;
          mdt_r <= mdt_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(CW - 1)) begin
            state_r <= ST_ABS;
          end
        end
        ST_ABS: begin
          // quotient fits the data width, so the high half is already below den
          neg_r   <= prod[HW+DW-1];
          rem_r   <= mag[DW+CW:DW];
          lo_r    <= mag[DW-1:0];
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= ge ? diff[CW:0] : trial[CW:0];
          lo_r  <= {lo_r[DW-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(DW - 1)) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.quot = lo_r;

endmodule

@@ rtl/timestamped_first_order_lowpass_top.sv @@
// ---------------------------------------------------------------------------
// timestamped_first_order_lowpass_top
// first-order low-pass filter whose step is the tick count elapsed on a
// down-counting timer; restarts from the sample after a long gap
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | in        | in_valid/in_ready | in_sample_in, in_timer_now
//  out     | out       | out_valid/out_ready | out_sample_out, out_restarted
//  cfg     | in        | cfg_we            | cfg_index, cfg_wdata
//
//  filtered items: the result is computed by 32 multiply and 32 divide steps
//  in tfol_muldiv; the next transfer is taken once the result has been loaded
//  restart and zero-denominator items skip tfol_muldiv and go to the finish state
//  one item in flight; in_ready is high only while the controller is idle
//  a finished result waits in the output register while the next item is taken
//  synchronous active-low reset clears stamp, previous output and control registers
// ---------------------------------------------------------------------------
`include "timestamped_first_order_lowpass_top_assert.svh"

module timestamped_first_order_lowpass_top #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tfol_pkg::DATA_W-1:0]  in_sample_in,
  input  logic        [TIMER_BITS-1:0]        in_timer_now,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tfol_pkg::DATA_W-1:0]  out_sample_out,
  output logic                                out_restarted,
  input  logic                                cfg_we,
  input  logic        [tfol_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [tfol_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int unsigned DW = tfol_pkg::DATA_W;
  localparam int unsigned CW = tfol_pkg::CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_FIN
  } ctl_state_t;

  ctl_state_t          state_r;
  logic [CW-1:0]       tc_r;
  logic [CW-1:0]       limit_r;
  logic [TIMER_BITS-1:0] stamp_r;
  logic [DW-1:0]       last_out_r;
  logic [DW-1:0]       x_r;
  logic [CW-1:0]       dt_r;
  logic [DW-1:0]       y_r;
  logic                rst_flag_r;
  logic                start_r;
  logic                out_valid_r;
  logic [DW-1:0]       out_data_r;
  logic                out_rst_r;

  logic [TIMER_BITS-1:0] dt_c;
  logic                restart_c;
  logic                den_zero_c;
  logic                accept;
  logic                out_free;

  tfol_pkg::md_req_t   md_req;
  tfol_pkg::md_rsp_t   md_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r    <= tfol_pkg::TC_RESET;
      limit_r <= tfol_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tfol_pkg::CFG_TC_IDX:    tc_r    <= cfg_wdata;
        tfol_pkg::CFG_LIMIT_IDX: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // elapsed ticks, equal stamps give the all-ones tick count
  always_comb begin
    if (in_timer_now < stamp_r) begin
      dt_c = stamp_r - in_timer_now;
    end else begin
      dt_c = ~in_timer_now + stamp_r;
    end
    restart_c  = (CW'(dt_c) > limit_r);
    den_zero_c = (tc_r == '0) && (dt_c == '0);
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stamp_r     <= '0;
      last_out_r  <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            stamp_r <= in_timer_now;
            x_r     <= in_sample_in;
            dt_r    <= CW'(dt_c);
            if (restart_c) begin
              y_r        <= in_sample_in;
              rst_flag_r <= 1'b1;
              state_r    <= ST_FIN;
            end else if (den_zero_c) begin
              y_r        <= last_out_r;
              rst_flag_r <= 1'b0;
              state_r    <= ST_FIN;
            end else begin
              rst_flag_r <= 1'b0;
              start_r    <= 1'b1;
              state_r    <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (md_rsp.done) begin
            y_r     <= md_rsp.neg ? DW'(0) - md_rsp.quot : md_rsp.quot;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= y_r;
            out_rst_r   <= rst_flag_r;
            last_out_r  <= y_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign md_req.start = start_r;
  assign md_req.tc    = tc_r;
  assign md_req.dt    = dt_r;
  assign md_req.prev  = last_out_r;
  assign md_req.x     = x_r;

  tfol_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign out_restarted  = out_rst_r;

  `TFOL_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != ST_IDLE, "transfer accepted but controller stayed idle")
  `TFOL_ASSERT_NEXT(a_restart_bypass, accept && restart_c, (state_r == ST_FIN) && rst_flag_r, "restart item did not bypass the filter")
  `TFOL_ASSERT_SAME(a_out_from_fin, $rose(out_valid_r), $past(state_r == ST_FIN), "output loaded outside the finish state")

endmodule
